FILE: hdl/bit_buffer_pack_unpack_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit buffer core.
// Shared concurrent assertion forms on the clock of the block, with or without its reset.
// ----------------------------------------------------------------------------
`ifndef BIT_BUFFER_PACK_UNPACK_CORE_MACROS_SVH
`define BIT_BUFFER_PACK_UNPACK_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define BBPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BBPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bbpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpu_pkg
// Field widths, operation and status codes, and helpers of the bit buffer.
// ----------------------------------------------------------------------------
package bbpu_pkg;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 6;
  localparam int OFFSET_W = 13;
  localparam int STATUS_W = 2;
  localparam int AVAIL_W  = 13;

  localparam int CAPACITY_BITS_DEF = 4096;
  localparam int MAX_FIELD_BITS    = 32;

  // A field of up to MAX_FIELD_BITS bits starting anywhere in a byte.
  localparam int MAX_BYTES = (MAX_FIELD_BITS + 6) / 8 + 1;
  localparam int BC_W      = $clog2(MAX_BYTES + 1);
  localparam int BUF_W     = 8 * MAX_BYTES;

  localparam int IN_FIELDS_W  = DATA_W + COUNT_W + OFFSET_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + COUNT_W + AVAIL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REWIND = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CAP   = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [COUNT_W-1:0]  count_out;
    logic [AVAIL_W-1:0]  avail;
  } result_t;

  function automatic logic [DATA_W-1:0] bit_rev(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    for (int i = 0; i < DATA_W; i++) begin
      r[i] = v[DATA_W-1-i];
    end
    return r;
  endfunction

endpackage

FILE: hdl/bbpu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bbpu_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpu_seq
// Operation sequencer: length and reader registers, byte-wise
// read-modify-write of the bit store, and the clearing sweep.
// ----------------------------------------------------------------------------
module bbpu_seq import bbpu_pkg::*; #(
  parameter int CAPACITY_BITS = CAPACITY_BITS_DEF,
  localparam int SB = (CAPACITY_BITS + 7) / 8,
  localparam int AW = $clog2(SB)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [DATA_W-1:0]   in_data,
  input  logic [COUNT_W-1:0]  in_count,
  input  logic [OFFSET_W-1:0] in_offset,
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [7:0]          ram_rdata
);

  localparam int LW    = $clog2(CAPACITY_BITS + 1);
  localparam int CW    = ((LW > OFFSET_W) ? LW : OFFSET_W) + 1;
  localparam int SUM_W = COUNT_W + 1;
  localparam int SH_W  = $clog2(BUF_W + 8);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_RUN   = 5'b00100,
    S_DONE  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [LW-1:0]       rpos_r, rpos_nxt;
  logic [AW-1:0]       clr_ctr_r, clr_ctr_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  logic [BC_W-1:0]     cyc_r, cyc_nxt;

  logic [FUNC_W-1:0]   func_r;
  logic [DATA_W-1:0]   data_r;
  logic [COUNT_W-1:0]  count_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [LW-1:0]       pos_r;
  logic [AW-1:0]       base_r;
  logic [BC_W-1:0]     nb_r;
  logic                wr_r;
  logic [DATA_W-1:0]   nmask_r;
  logic [BUF_W-1:0]    wd_r, wd_nxt;
  logic [BUF_W-1:0]    mask_r, mask_nxt;
  logic [BUF_W-1:0]    buf_r, buf_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [COUNT_W-1:0]  cnt_out_r;

  // Setup decode.
  logic [CW-1:0]       len_cw, rpos_cw, off_cw, cnt_cw, avail_cw;
  logic [COUNT_W-1:0]  rd_n;
  logic [LW-1:0]       s_pos, s_len, s_rpos;
  logic [COUNT_W-1:0]  s_n, s_cnt_out;
  logic                s_wr, s_clear;
  logic [DATA_W-1:0]   s_aligned, s_nmask;
  logic [STATUS_W-1:0] s_status;
  logic [2:0]          s_lo;
  logic [BUF_W-1:0]    s_mask, s_wd;
  logic [BC_W-1:0]     s_nb;

  // Result assembly.
  logic [SH_W-1:0]     ex_sh;
  logic [DATA_W-1:0]   ex_field, ex_dout;
  logic [COUNT_W-1:0]  cnt_sat;

  assign cnt_sat = (in_count > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS) : in_count;

  always_comb begin
    len_cw   = CW'(len_r);
    rpos_cw  = CW'(rpos_r);
    off_cw   = CW'(offset_r);
    cnt_cw   = CW'(count_r);
    avail_cw = len_cw - rpos_cw;
    rd_n     = (cnt_cw > avail_cw) ? COUNT_W'(avail_cw) : count_r;

    s_pos     = '0;
    s_n       = '0;
    s_wr      = 1'b0;
    s_aligned = '0;
    s_status  = ST_OK;
    s_cnt_out = '0;
    s_len     = len_r;
    s_rpos    = rpos_r;
    s_clear   = 1'b0;
    unique case (func_r) inside
      FN_APPEND: begin
        if (len_cw + cnt_cw > CW'(CAPACITY_BITS)) begin
          s_status = ST_CAP;
        end else begin
          s_pos     = len_r;
          s_n       = count_r;
          s_wr      = 1'b1;
          // First bit of the field goes to the lowest store position.
          s_aligned = bit_rev(data_r) >> (COUNT_W'(MAX_FIELD_BITS) - count_r);
          s_cnt_out = count_r;
          s_len     = len_r + LW'(count_r);
        end
      end
      FN_SET, FN_GET: begin
        if (off_cw >= len_cw) begin
          s_status = ST_RANGE;
        end else begin
          s_pos     = LW'(offset_r);
          s_n       = COUNT_W'(1);
          s_wr      = (func_r == FN_SET);
          s_aligned = DATA_W'(|data_r);
        end
      end
      FN_READ: begin
        s_pos     = rpos_r;
        s_n       = rd_n;
        s_cnt_out = rd_n;
        s_rpos    = rpos_r + LW'(rd_n);
      end
      FN_REWIND: begin
        s_rpos = '0;
      end
      FN_CLEAR: begin
        s_clear = 1'b1;
        s_rpos  = '0;
        if (off_cw > CW'(CAPACITY_BITS)) begin
          s_len    = LW'(CAPACITY_BITS);
          s_status = ST_RANGE;
        end else begin
          s_len = LW'(offset_r);
        end
      end
      default: begin
      end
    endcase

    s_lo    = s_pos[2:0];
    s_nmask = {DATA_W{1'b1}} >> (COUNT_W'(MAX_FIELD_BITS) - s_n);
    s_mask  = BUF_W'(s_nmask) << s_lo;
    s_wd    = (BUF_W'(s_aligned) << s_lo) & s_mask;
    s_nb    = (s_n == '0) ? '0
            : BC_W'((SUM_W'(s_lo) + SUM_W'(s_n) - SUM_W'(1)) >> 3) + BC_W'(1);
  end

  // Bytes enter the buffer at the top, so the first byte ends up at
  // BUF_W - 8*nb; the field starts a further lo bits up.
  always_comb begin
    ex_sh    = SH_W'(BUF_W) - SH_W'({nb_r, 3'b000}) + SH_W'(pos_r[2:0]);
    ex_field = DATA_W'(buf_r >> ex_sh) & nmask_r;
    ex_dout  = '0;
    unique case (func_r) inside
      FN_READ: begin
        ex_dout = bit_rev(ex_field) >> (COUNT_W'(MAX_FIELD_BITS) - count_r);
      end
      FN_SET, FN_GET: begin
        ex_dout = (status_r == ST_OK) ? DATA_W'(ex_field[0]) : '0;
      end
      default: begin
        ex_dout = '0;
      end
    endcase
  end

  assign res.status    = status_r;
  assign res.data_out  = ex_dout;
  assign res.count_out = cnt_out_r;
  assign res.avail     = AVAIL_W'(CW'(len_r) - CW'(rpos_r));

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    rpos_nxt     = rpos_r;
    clr_ctr_nxt  = clr_ctr_r;
    clr_resp_nxt = clr_resp_r;
    cyc_nxt      = cyc_r;
    wd_nxt       = wd_r;
    mask_nxt     = mask_r;
    buf_nxt      = buf_r;
    ram_we       = 1'b0;
    ram_waddr    = base_r + AW'(cyc_r - BC_W'(1));
    ram_wdata    = (ram_rdata & ~mask_r[7:0]) | wd_r[7:0];
    ram_re       = 1'b0;
    ram_raddr    = base_r + AW'(cyc_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        len_nxt  = s_len;
        rpos_nxt = s_rpos;
        cyc_nxt  = '0;
        wd_nxt   = s_wd;
        mask_nxt = s_mask;
        if (s_clear) begin
          clr_ctr_nxt  = '0;
          clr_resp_nxt = 1'b1;
          state_nxt    = S_CLEAR;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // Read byte cyc while merging and writing back byte cyc-1.
        ram_re = (cyc_r < nb_r);
        if (cyc_r != '0) begin
          buf_nxt  = {ram_rdata, buf_r[BUF_W-1:8]};
          wd_nxt   = wd_r >> 8;
          mask_nxt = mask_r >> 8;
          ram_we   = wr_r;
        end
        if (cyc_r == nb_r) begin
          state_nxt = S_DONE;
        end else begin
          cyc_nxt = cyc_r + BC_W'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ctr_r;
        ram_wdata = '0;
        if (clr_ctr_r == AW'(SB - 1)) begin
          state_nxt = clr_resp_r ? S_DONE : S_IDLE;
        end else begin
          clr_ctr_nxt = clr_ctr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      len_r      <= '0;
      rpos_r     <= '0;
      clr_ctr_r  <= '0;
      clr_resp_r <= 1'b0;
      cyc_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      rpos_r     <= rpos_nxt;
      clr_ctr_r  <= clr_ctr_nxt;
      clr_resp_r <= clr_resp_nxt;
      cyc_r      <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r   <= in_func;
      data_r   <= in_data;
      count_r  <= cnt_sat;
      offset_r <= in_offset;
    end
    if (state_r == S_SETUP) begin
      pos_r     <= s_pos;
      base_r    <= AW'(s_pos >> 3);
      nb_r      <= s_nb;
      wr_r      <= s_wr;
      nmask_r   <= s_nmask;
      status_r  <= s_status;
      cnt_out_r <= s_cnt_out;
    end
    wd_r   <= wd_nxt;
    mask_r <= mask_nxt;
    buf_r  <= buf_nxt;
  end

endmodule

FILE: hdl/bit_buffer_pack_unpack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_buffer_pack_unpack_core
// Bit buffer with append, single-bit set and get, and a sequential reader,
// kept in a byte-wide store that fills LSB-first.
//
//   Channel  Direction  Carries
//   in_      slave      one operation per beat
//   out_     master     one result per beat
//
// An operation touches nb store bytes (0 to 5). After acceptance it is decoded
// in a setup state, then the byte loop reads one byte while writing back the
// previous one through the RAM, and the result passes to the output register.
// Clear and reset sweep the store one byte per cycle (all (CAPACITY_BITS+7)/8
// bytes, 512 by default); no beat is taken during the sweep after reset.
// A waiting result sits in the output register while the next operation
// runs; that one then holds until the register is free.
// ----------------------------------------------------------------------------
module bit_buffer_pack_unpack_core import bbpu_pkg::*; #(
  parameter int CAPACITY_BITS = CAPACITY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // data[31:0], count[37:32], offset[50:38], zero pad above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [FUNC_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // data_out[31:0], count_out[37:32], avail[50:38], zero pad above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]    out_tuser
);

  localparam int SB = (CAPACITY_BITS + 7) / 8;
  localparam int AW = $clog2(SB);

  logic          res_valid, res_ready;
  result_t       res;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic    out_valid_r;
  result_t out_res_r;

  bbpu_seq #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_data   (in_tdata[DATA_W-1:0]),
    .in_count  (in_tdata[DATA_W +: COUNT_W]),
    .in_offset (in_tdata[DATA_W+COUNT_W +: OFFSET_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bbpu_ram #(
    .WIDTH(8),
    .DEPTH(SB)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_res_r.avail,
                       out_res_r.count_out, out_res_r.data_out};

endmodule

FILE: hdl/bbpu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpu_checker
// Port-level checks of the bit buffer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "bit_buffer_pack_unpack_core_macros.svh"

module bbpu_checker import bbpu_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  localparam int CNT_LSB = DATA_W;

  // A stalled result beat keeps its value.
  `BBPU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // The store is swept after reset, so nothing is taken or shown right after it.
  `BBPU_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !in_tready && !out_tvalid, "beat handshake open right after reset")

  // Operations are taken one at a time.
  `BBPU_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "second operation taken back to back")

  // A rejected append reports no bits and no data.
  `BBPU_ASSERT(a_cap_reject, out_tvalid && out_tuser == ST_CAP |-> out_tdata[CNT_LSB+COUNT_W-1:0] == '0, "rejected append reports bits")

  // No result moves more bits than one field holds.
  `BBPU_ASSERT(a_count_max, out_tvalid |-> out_tdata[CNT_LSB +: COUNT_W] <= COUNT_W'(MAX_FIELD_BITS), "result count above field size")

endmodule

bind bit_buffer_pack_unpack_core bbpu_checker u_bbpu_checker (.*);
